>>> rtl/cnfsa_pkg.sv
// Shared types, constants and helper functions of the circular slot allocator.
// No dependencies; imported by the interfaces, the RAM user and the top level.
package cnfsa_pkg;

  localparam int SLOT_W            = 10;
  localparam int STATUS_W          = 2;
  localparam int CFG_W             = 11;
  localparam int WORD_W            = 32;
  localparam int BIT_W             = 5;
  localparam int SLOT_SPAN         = 1024;
  localparam int NUM_SLOTS_DEFAULT = 1024;
  localparam int PADDR_W           = 2;
  localparam int PDATA_W           = 32;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_SLOT = 2'd2
  } status_e;

  localparam logic [PADDR_W-1:0] ADDR_SLOTS_IN_USE = 2'd0;
  localparam logic [CFG_W-1:0]   SLOTS_IN_USE_RST  = 11'd1024;

  // Index of the lowest set bit; zero for an empty word.
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

  // Bits strictly below position b.
  function automatic logic [WORD_W-1:0] below_mask(input logic [BIT_W-1:0] b);
    return (WORD_W'(1) << b) - WORD_W'(1);
  endfunction

  // Bits at or below position b.
  function automatic logic [WORD_W-1:0] upto_mask(input logic [BIT_W-1:0] b);
    return ((WORD_W'(1) << b) << 1) - WORD_W'(1);
  endfunction

endpackage

>>> rtl/cnfsa_req_if.sv
// Request channel of the slot allocator: command and slot with valid/ready.
// Depends on cnfsa_pkg.
interface cnfsa_req_if import cnfsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, command, slot, input ready);
  modport sink   (input valid, command, slot, output ready);
endinterface

>>> rtl/cnfsa_rsp_if.sv
// Response channel of the slot allocator: granted slot and status with valid/ready.
// Depends on cnfsa_pkg.
interface cnfsa_rsp_if import cnfsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   granted_slot;
  logic [STATUS_W-1:0] status;

  modport source (output valid, granted_slot, status, input ready);
  modport sink   (input valid, granted_slot, status, output ready);
endinterface

>>> rtl/circular_next_free_slot_allocator.sv
// Circular next-free slot allocator: occupancy words in a RAM plus a word summary.
// Depends on cnfsa_pkg, cnfsa_req_if, cnfsa_rsp_if and cnfsa_ram.
//
// Usage:
//   req_i carries command (allocate / release) and slot; rsp_o returns
//   granted_slot and status, one response per request, in order.
//   The APB port holds slots_in_use at address 0; write it only while idle.
// Timing:
//   One request is processed at a time. A bad slot goes straight to the
//   response; a release or an allocate that hits the preferred word reads
//   that word only, and the search may also read the last active word and
//   then a further word. The steps are set by the occupancy RAM and its
//   registered read data: each word visited costs one read. The response
//   sits in an output register, so a new request is taken while the
//   previous response waits.
// Reset:
//   All slots free, slots_in_use = 1024. Per-word valid flags stand in for a
//   cleared RAM, so no clearing pass is needed and requests flow at once.
// Back-pressure:
//   If rsp_o is stalled with a response pending, the next result waits in the
//   block and no further request is taken until the output register frees.
module circular_next_free_slot_allocator import cnfsa_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  cnfsa_req_if.sink          req_i,
  cnfsa_rsp_if.source        rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int NCAP   = (NUM_SLOTS < SLOT_SPAN) ? NUM_SLOTS : SLOT_SPAN;
  localparam int NW_RAW = (NCAP + WORD_W - 1) / WORD_W;
  localparam int NWORDS = (NW_RAW < 2) ? 2 : NW_RAW;
  localparam int WIDX_W = $clog2(NWORDS);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_RD_FIRST = 6'b000010,
    S_RD_LAST  = 6'b000100,
    S_SEARCH   = 6'b001000,
    S_RD_CAND  = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [CFG_W-1:0]    slots_q, slots_d;
  logic [NWORDS-1:0]   full_q, full_d;
  logic [NWORDS-1:0]   vld_q, vld_d;
  logic                rd_vld_q, rd_vld_d;
  logic                lwok_q, lwok_d;
  logic                out_vld_q, out_vld_d;

  cmd_e                cmd_q, cmd_d;
  logic [WIDX_W-1:0]   ws_q, ws_d;
  logic [BIT_W-1:0]    off_q, off_d;
  logic [WORD_W-1:0]   wsw_q, wsw_d;
  logic [WIDX_W-1:0]   cw_q, cw_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  status_e             res_status_q, res_status_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;
  status_e             out_status_q, out_status_d;

  logic                ram_we, ram_re;
  logic [WIDX_W-1:0]   ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata, rdword;

  logic [CFG_W-1:0]    n_act, nm1;
  logic [WIDX_W-1:0]   lw;
  logic [WORD_W-1:0]   lastmask, ws_act, cw_act;
  logic [WORD_W-1:0]   hi_free, lo_free, cand_free;
  logic                in_fire, in_bad, cfg_wr;
  logic [WIDX_W-1:0]   in_ws;

  logic [NWORDS-1:0]   cand;
  logic [WIDX_W-1:0]   cand_hi, cand_any, cand_idx;
  logic                cand_hi_found, cand_any_found;

  cnfsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr == ADDR_SLOTS_IN_USE);
  assign prdata = (paddr == ADDR_SLOTS_IN_USE) ? PDATA_W'(slots_q) : '0;
  assign slots_d = cfg_wr ? pwdata[CFG_W-1:0] : slots_q;

  // Active range
  assign n_act    = (slots_q > CFG_W'(NCAP)) ? CFG_W'(NCAP) : slots_q;
  assign nm1      = n_act - CFG_W'(1);
  assign lw       = nm1[WIDX_W+BIT_W-1:BIT_W];
  assign lastmask = upto_mask(nm1[BIT_W-1:0]);

  // A word never written reads as all free
  assign rdword = rd_vld_q ? ram_rdata : '0;

  assign in_fire = req_i.valid & req_i.ready;
  assign in_ws   = req_i.slot[WIDX_W+BIT_W-1:BIT_W];
  assign in_bad  = {1'b0, req_i.slot} >= n_act;

  assign ws_act    = (ws_q == lw) ? lastmask : '1;
  assign cw_act    = (cw_q == lw) ? lastmask : '1;
  assign hi_free   = ~rdword & ~below_mask(off_q) & ws_act;
  assign lo_free   = ~wsw_q & below_mask(off_q) & ws_act;
  assign cand_free = ~rdword & cw_act;

  // Summary search over the other active words, wrapping after the last one
  always_comb begin
    cand           = '0;
    cand_hi        = '0;
    cand_any       = '0;
    cand_hi_found  = 1'b0;
    cand_any_found = 1'b0;
    for (int i = 0; i < NWORDS; i++) begin
      cand[i] = (WIDX_W'(i) == lw) ? lwok_q : ~full_q[i];
      cand[i] = cand[i] & (WIDX_W'(i) <= lw) & (WIDX_W'(i) != ws_q);
    end
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        cand_any       = WIDX_W'(i);
        cand_any_found = 1'b1;
        if (WIDX_W'(i) > ws_q) begin
          cand_hi       = WIDX_W'(i);
          cand_hi_found = 1'b1;
        end
      end
    end
  end

  assign cand_idx = cand_hi_found ? cand_hi : cand_any;

  always_comb begin
    state_d      = state_q;
    rd_vld_d     = rd_vld_q;
    lwok_d       = lwok_q;
    out_vld_d    = out_vld_q;
    cmd_d        = cmd_q;
    ws_d         = ws_q;
    off_d        = off_q;
    wsw_d        = wsw_q;
    cw_d         = cw_q;
    res_slot_d   = res_slot_q;
    res_status_d = res_status_q;
    out_slot_d   = out_slot_q;
    out_status_d = out_status_q;
    full_d       = full_q;
    vld_d        = vld_q;
    ram_we       = 1'b0;
    ram_waddr    = ws_q;
    ram_wdata    = wsw_q;
    ram_re       = 1'b0;
    ram_raddr    = ws_q;

    if (rsp_o.valid && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_d        = cmd_e'(req_i.command);
          ws_d         = in_ws;
          off_d        = req_i.slot[BIT_W-1:0];
          res_slot_d   = '0;
          res_status_d = ST_OK;
          if (in_bad) begin
            res_status_d = ST_BAD_SLOT;
            state_d      = S_DONE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = in_ws;
            state_d   = S_RD_FIRST;
          end
        end
      end
      S_RD_FIRST: begin
        wsw_d = rdword;
        if (cmd_q == CMD_RELEASE) begin
          if (rdword[off_q]) begin
            ram_we    = 1'b1;
            ram_waddr = ws_q;
            ram_wdata = rdword & ~(WORD_W'(1) << off_q);
          end else begin
            res_status_d = ST_BAD_SLOT;
          end
          state_d = S_DONE;
        end else if (|hi_free) begin
          ram_we     = 1'b1;
          ram_waddr  = ws_q;
          ram_wdata  = rdword | (WORD_W'(1) << lowest_set(hi_free));
          res_slot_d = SLOT_W'({ws_q, lowest_set(hi_free)});
          state_d    = S_DONE;
        end else if (ws_q == lw) begin
          lwok_d  = 1'b0;
          state_d = S_SEARCH;
        end else begin
          // the summary cannot see the inactive tail of the last word: read it
          ram_re    = 1'b1;
          ram_raddr = lw;
          state_d   = S_RD_LAST;
        end
      end
      S_RD_LAST: begin
        lwok_d  = |(~rdword & lastmask);
        state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (cand_any_found) begin
          ram_re    = 1'b1;
          ram_raddr = cand_idx;
          cw_d      = cand_idx;
          state_d   = S_RD_CAND;
        end else if (|lo_free) begin
          // wrapped all the way round to the part below the preferred slot
          ram_we     = 1'b1;
          ram_waddr  = ws_q;
          ram_wdata  = wsw_q | (WORD_W'(1) << lowest_set(lo_free));
          res_slot_d = SLOT_W'({ws_q, lowest_set(lo_free)});
          state_d    = S_DONE;
        end else begin
          res_status_d = ST_FULL;
          state_d      = S_DONE;
        end
      end
      S_RD_CAND: begin
        if (|cand_free) begin
          ram_we     = 1'b1;
          ram_waddr  = cw_q;
          ram_wdata  = rdword | (WORD_W'(1) << lowest_set(cand_free));
          res_slot_d = SLOT_W'({cw_q, lowest_set(cand_free)});
        end else begin
          res_status_d = ST_FULL;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d    = 1'b1;
          out_slot_d   = res_slot_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ram_re) begin
      rd_vld_d = vld_q[ram_raddr];
    end
    if (ram_we) begin
      full_d[ram_waddr] = &ram_wdata;
      vld_d[ram_waddr]  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      slots_q   <= SLOTS_IN_USE_RST;
      full_q    <= '0;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      lwok_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      slots_q   <= slots_d;
      full_q    <= full_d;
      vld_q     <= vld_d;
      rd_vld_q  <= rd_vld_d;
      lwok_q    <= lwok_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    ws_q         <= ws_d;
    off_q        <= off_d;
    wsw_q        <= wsw_d;
    cw_q         <= cw_d;
    res_slot_q   <= res_slot_d;
    res_status_q <= res_status_d;
    out_slot_q   <= out_slot_d;
    out_status_q <= out_status_d;
  end

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.granted_slot = out_slot_q;
  assign rsp_o.status       = out_status_q;

endmodule

>>> rtl/cnfsa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module cnfsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
